FILE: design/wimo_pkg.sv
// Shared types and constants for the weighted image moment block.
// No dependencies; imported by the interfaces and every module.
`default_nettype none
package wimo_pkg;

  localparam int COORD_W   = 16;
  localparam int VAL_W     = 16;
  localparam int WGT_W     = 16;
  localparam int ORD_W     = 3;
  localparam int MOM_W     = 64;
  localparam int BASE_W    = 48;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_CENTROID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTROID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER      = 2'd2;

  localparam logic [ORD_W-1:0] ORDER_RESET = 3'd2;

  // One classified pixel, handed from front to back.
  typedef struct packed {
    logic [BASE_W-1:0]  base_mag;  // |value| * window * pixel weight
    logic [COORD_W-1:0] ax;        // |dx|
    logic [COORD_W-1:0] ay;        // |dy|
    logic               vneg;
    logic               xneg;
    logic               yneg;
    logic [ORD_W-1:0]   order;     // clamped active order
    logic               last;
  } queue_item_t;

endpackage
`default_nettype wire

FILE: design/wimo_if.sv
// Channel interfaces: pixel input, moment output, register writes.
// Depends on wimo_pkg.
`default_nettype none
interface pixel_if
  import wimo_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   pixel_value;
  logic [WGT_W-1:0]   window_weight;
  logic [WGT_W-1:0]   pixel_weight;
  logic [COORD_W-1:0] pos_x;
  logic [COORD_W-1:0] pos_y;
  logic               last_pixel;
  modport source (output valid, pixel_value, window_weight, pixel_weight, pos_x, pos_y,
                  last_pixel, input ready);
  modport sink (input valid, pixel_value, window_weight, pixel_weight, pos_x, pos_y,
                last_pixel, output ready);
endinterface

interface moment_if
  import wimo_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [MOM_W-1:0] moment_value;
  logic [ORD_W-1:0] x_power;
  logic [ORD_W-1:0] y_power;
  logic             last_moment;
  modport source (output valid, moment_value, x_power, y_power, last_moment, input ready);
  modport sink (input valid, moment_value, x_power, y_power, last_moment, output ready);
endinterface

interface cfg_if
  import wimo_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/wimo_front.sv
// Front end: register file, pixel accept, offsets and weight product.
// Depends on wimo_pkg and wimo_if.
`default_nettype none
module wimo_front
  import wimo_pkg::*;
#(
  parameter int MAX_ORDER = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pixel_if.sink      pix,
  cfg_if.sink        cfg,
  input  wire logic  hold,
  input  wire logic  q_full,
  output queue_item_t q_data,
  output logic       q_push
);

  logic signed [COORD_W-1:0] centroid_x, centroid_y;
  logic [ORD_W-1:0]          moment_order;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      centroid_x   <= '0;
      centroid_y   <= '0;
      moment_order <= ORDER_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CENTROID_X: centroid_x <= cfg.data;
        REG_CENTROID_Y: centroid_y <= cfg.data;
        REG_ORDER:      moment_order <= cfg.data[ORD_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: offsets and magnitudes; stage 2: first weight product
  logic               s1_v, s2_v, s1_adv, s2_adv, acc_in;
  logic [VAL_W-1:0]   s1_av;
  logic [WGT_W-1:0]   s1_ww, s1_pw, s2_pw;
  logic [31:0]        s2_p1;
  queue_item_t        s1_it, s2_it;
  logic signed [COORD_W:0] dx, dy;
  logic [ORD_W-1:0]   ord_clamp;

  assign s2_adv = s2_v && !q_full;
  assign s1_adv = s1_v && (!s2_v || s2_adv);
  assign pix.ready = !hold && (!s1_v || !s2_v || s2_adv);
  assign acc_in = pix.valid && pix.ready;
  assign q_push = s2_adv;

  assign dx = {pix.pos_x[COORD_W-1], pix.pos_x} - {centroid_x[COORD_W-1], centroid_x};
  assign dy = {pix.pos_y[COORD_W-1], pix.pos_y} - {centroid_y[COORD_W-1], centroid_y};
  assign ord_clamp = (int'(moment_order) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : moment_order;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (acc_in) s1_v <= 1'b1;
      else if (s1_adv) s1_v <= 1'b0;
      if (s1_adv) s2_v <= 1'b1;
      else if (s2_adv) s2_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_av <= pix.pixel_value[VAL_W-1] ? VAL_W'(17'd0 - {1'b1, pix.pixel_value})
                                        : pix.pixel_value;
      s1_ww <= pix.window_weight;
      s1_pw <= pix.pixel_weight;
      s1_it.base_mag <= '0;
      s1_it.ax    <= dx[COORD_W] ? COORD_W'(-dx) : COORD_W'(dx);
      s1_it.ay    <= dy[COORD_W] ? COORD_W'(-dy) : COORD_W'(dy);
      s1_it.vneg  <= pix.pixel_value[VAL_W-1];
      s1_it.xneg  <= dx[COORD_W];
      s1_it.yneg  <= dy[COORD_W];
      s1_it.order <= ord_clamp;
      s1_it.last  <= pix.last_pixel;
    end
    if (s1_adv) begin
      s2_p1 <= s1_av * s1_ww;
      s2_pw <= s1_pw;
      s2_it <= s1_it;
    end
  end

  always_comb begin
    q_data = s2_it;
    q_data.base_mag = s2_p1 * s2_pw;
  end

endmodule
`default_nettype wire

FILE: design/wimo_fifo.sv
// Two-entry queue of classified pixels between front and back.
// Depends on wimo_pkg.
`default_nettype none
module wimo_fifo
  import wimo_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  queue_item_t wdata,
  output logic       full,
  input  wire logic  pop,
  output logic       nonempty,
  output queue_item_t rdata
);

  queue_item_t mem [2];
  logic        wp, rp;
  logic [1:0]  count;

  assign full = count == 2'd2;
  assign nonempty = count != 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

endmodule
`default_nettype wire

FILE: design/wimo_back.sv
// Back end: bit-serial power products, term scaling, accumulator memory,
// emission and clearing sweep. Depends on wimo_pkg and wimo_if.
`default_nettype none
module wimo_back
  import wimo_pkg::*;
#(
  parameter int MAX_ORDER       = 4,
  parameter int COORD_FRAC_BITS = 4
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  queue_item_t q_data,
  output logic       q_pop,
  output logic       clearing,
  moment_if.source   mom
);

  localparam int NUM_ACC = (MAX_ORDER + 1) * (MAX_ORDER + 2) / 2;
  localparam int AW = (NUM_ACC > 1) ? $clog2(NUM_ACC) : 1;
  localparam int NW = $clog2(MAX_ORDER + 2);
  localparam int W  = BASE_W + COORD_W * MAX_ORDER;

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_TERM      = 7'b0000100,
    S_ACC       = 7'b0001000,
    S_MUL       = 7'b0010000,
    S_EMIT_RD   = 7'b0100000,
    S_EMIT_WAIT = 7'b1000000
  } back_state_t;

  back_state_t state;
  logic [W-1:0]       pmag, tmag, mcand, prod;
  logic [COORD_W-1:0] mult, ax, ay;
  logic [NW-1:0]      px, py, en, ej;
  logic [ORD_W-1:0]   ord;
  logic               vneg, xneg, yneg, last, row;
  logic [AW-1:0]      clr, ra, wa, term_idx, emit_idx;
  logic [MOM_W-1:0]   rdata, wd, term, term_next, sum_sat;
  logic               we;
  logic [MOM_W-1:0]   acc_mem [NUM_ACC];
  logic [MOM_W-1:0]   out_value;
  logic [ORD_W-1:0]   out_xp, out_yp;
  logic               out_last;

  function automatic logic [AW-1:0] tri_idx(input logic [NW-1:0] n, input logic [NW-1:0] j);
    int t;
    t = ((int'(n) * (int'(n) + 1)) >> 1) + int'(j);
    return AW'(t);
  endfunction

  assign term_idx = tri_idx(NW'(px + py), py);
  assign emit_idx = tri_idx(en, ej);
  assign clearing = state == S_CLEAR;
  assign q_pop = (state == S_IDLE) && q_valid;

  // Shift by COORD_FRAC_BITS*n+30 with floor, then saturate to 64 bits.
  always_comb begin
    int k;
    logic [W-1:0] sh;
    logic [W:0]   m;
    logic         rem, neg;
    k   = COORD_FRAC_BITS * (int'(px) + int'(py)) + 30;
    neg = vneg ^ (xneg & px[0]) ^ (yneg & py[0]);
    sh  = tmag >> k;
    rem = |(tmag & ~({W{1'b1}} << k));
    m   = {1'b0, sh} + (W+1)'(rem);
    if (!neg) begin
      term_next = (|sh[W-1:MOM_W-1]) ? {1'b0, {(MOM_W-1){1'b1}}} : sh[MOM_W-1:0];
    end else begin
      term_next = (|m[W:MOM_W-1]) ? {1'b1, {(MOM_W-1){1'b0}}} : MOM_W'(-m[MOM_W-1:0]);
    end
  end

  always_comb begin
    logic [MOM_W:0] s;
    s = {rdata[MOM_W-1], rdata} + {term[MOM_W-1], term};
    if (s[MOM_W] != s[MOM_W-1])
      sum_sat = s[MOM_W] ? {1'b1, {(MOM_W-1){1'b0}}} : {1'b0, {(MOM_W-1){1'b1}}};
    else
      sum_sat = s[MOM_W-1:0];
  end

  // hold the emission address while a moment waits so the read data stays put
  always_comb begin
    ra = ((state == S_EMIT_RD) || (state == S_EMIT_WAIT)) ? emit_idx : term_idx;
    we = (state == S_ACC) || (state == S_CLEAR);
    wa = (state == S_CLEAR) ? clr : term_idx;
    wd = (state == S_CLEAR) ? '0 : sum_sat;
  end

  always_ff @(posedge clk) begin
    if (we) acc_mem[wa] <= wd;
    rdata <= acc_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (int'(clr) == NUM_ACC - 1) begin
            clr <= '0;
            state <= S_IDLE;
          end else begin
            clr <= clr + AW'(1);
          end
        end
        S_IDLE: if (q_valid) state <= S_TERM;
        S_TERM: state <= S_ACC;
        S_ACC: begin
          if (int'(px) + int'(py) < int'(ord)) state <= S_MUL;
          else if (int'(px) < int'(ord)) state <= S_MUL;
          else if (last) state <= S_EMIT_RD;
          else state <= S_IDLE;
        end
        S_MUL: if (mult == '0) state <= S_TERM;
        S_EMIT_RD: state <= S_EMIT_WAIT;
        S_EMIT_WAIT: begin
          if (mom.ready) state <= out_last ? S_CLEAR : S_EMIT_RD;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  // datapath: no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        pmag <= W'(q_data.base_mag);
        tmag <= W'(q_data.base_mag);
        ax <= q_data.ax;
        ay <= q_data.ay;
        vneg <= q_data.vneg;
        xneg <= q_data.xneg;
        yneg <= q_data.yneg;
        ord <= q_data.order;
        last <= q_data.last;
        px <= '0;
        py <= '0;
        en <= '0;
        ej <= '0;
      end
      S_TERM: term <= term_next;
      S_ACC: begin
        prod <= '0;
        if (int'(px) + int'(py) < int'(ord)) begin
          mcand <= tmag;
          mult <= ay;
          py <= py + NW'(1);
          row <= 1'b0;
        end else begin
          mcand <= pmag;
          mult <= ax;
          px <= px + NW'(1);
          py <= '0;
          row <= 1'b1;
        end
      end
      S_MUL: begin
        if (mult == '0) begin
          tmag <= prod;
          if (row) pmag <= prod;
        end else begin
          if (mult[0]) prod <= prod + mcand;
          mcand <= mcand << 1;
          mult <= mult >> 1;
        end
      end
      S_EMIT_RD: ;
      S_EMIT_WAIT: begin
        if (mom.ready && !out_last) begin
          if (ej == en) begin
            en <= en + NW'(1);
            ej <= '0;
          end else begin
            ej <= ej + NW'(1);
          end
        end
      end
      default: ;
    endcase
    if (state == S_EMIT_RD) begin
      out_value <= rdata;
      out_xp <= ORD_W'(en - ej);
      out_yp <= ORD_W'(ej);
      out_last <= (int'(en) == int'(ord)) && (ej == en);
    end
  end

  // read data for the emission lands in the cycle after EMIT_RD
  assign mom.valid        = state == S_EMIT_WAIT;
  assign mom.moment_value = (state == S_EMIT_WAIT) ? rdata : out_value;
  assign mom.x_power      = out_xp;
  assign mom.y_power      = out_yp;
  assign mom.last_moment  = out_last;

  a_acc_after_term: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC) |-> ($past(state) == S_TERM))
    else $error("accumulate without term stage");
  a_emit_done_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_WAIT && mom.ready && out_last) |=> (state == S_CLEAR))
    else $error("no clearing sweep after last moment");
  a_pop_starts_term: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state == S_TERM))
    else $error("popped item not processed");

endmodule
`default_nettype wire

FILE: design/weighted_image_moments_order_n.sv
// Top level of the weighted central image moment block.
// Depends on wimo_pkg, wimo_if, wimo_front, wimo_fifo and wimo_back.
//
//   channel  dir  handshake         payload
//   pix      in   valid/ready       pixel_value, weights, pos_x/pos_y, last_pixel
//   mom      out  valid/ready       moment_value, x_power, y_power, last_moment
//   cfg      in   valid/ready (=1)  index, data
//
// Flow: the front passes a pixel through two register stages before it
// enters the queue. The back pops it, then for each moment term runs a
// TERM and an ACC state, with one bit-serial multiply between consecutive
// terms whose length is set by the highest set bit of |dx| or |dy|; there
// are T = (N+1)(N+2)/2 terms. Emission reads each moment in EMIT_RD and
// offers it in EMIT_WAIT until the output takes it. The shared shift-add
// multiplier sets the rate.
// Reset: synchronous; afterwards a clearing sweep over all NUM_ACC
// accumulators runs (15 at the default order) during which no pixel is
// taken; the same sweep follows every emission. A stalled output holds the
// back end; the two-entry queue lets the front keep taking pixels meanwhile.
`default_nettype none
module weighted_image_moments_order_n
  import wimo_pkg::*;
#(
  parameter int MAX_ORDER       = 4,
  parameter int COORD_FRAC_BITS = 4
) (
  input wire logic clk,
  input wire logic rst,
  pixel_if.sink    pix,
  moment_if.source mom,
  cfg_if.sink      cfg
);

  queue_item_t push_data, pop_data;
  logic        push, q_full, pop, q_nonempty, clearing;

  // Front: hold off new pixels while the accumulators are being swept.
  wimo_front #(.MAX_ORDER(MAX_ORDER)) u_front (
    .clk(clk), .rst(rst), .pix(pix), .cfg(cfg),
    .hold(clearing), .q_full(q_full), .q_data(push_data), .q_push(push)
  );

  // Queue: decouple front from back so each stalls on its own.
  wimo_fifo u_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(push_data), .full(q_full),
    .pop(pop), .nonempty(q_nonempty), .rdata(pop_data)
  );

  // Back: accumulate every term, emit on the last pixel, then clear.
  wimo_back #(.MAX_ORDER(MAX_ORDER), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_nonempty), .q_data(pop_data),
    .q_pop(pop), .clearing(clearing), .mom(mom)
  );

endmodule
`default_nettype wire
